// File: rtl/gtfd_pkg.sv
// Shared types and constants of the time frame dimmer.
package gtfd_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } gtfd_in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_char;
        logic [7:0] duty_out;
        logic       drive_out;
        logic       led_out;
    } gtfd_out_t;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_IDLE = 1'b1;

    localparam logic [7:0] SYNC_ONE   = 8'hB5;
    localparam logic [7:0] SYNC_TWO   = 8'h62;
    localparam logic [7:0] CLASS_NAV  = 8'h01;
    localparam logic [7:0] ID_TIMEUTC = 8'h21;
    localparam logic [7:0] SET_START  = 8'hB9;

    localparam logic [7:0] CHAR_READY   = 8'h52;
    localparam logic [7:0] CHAR_UPDATED = 8'h55;

    localparam logic [7:0] IDLE_RESET = 8'd250;

    localparam logic [15:0] WINTER_FROM  = 16'd1031;
    localparam logic [15:0] WINTER_UNTIL = 16'd331;
    localparam logic [15:0] OFFSET_WINTER = 16'd200;
    localparam logic [15:0] OFFSET_SUMMER = 16'd100;

    // Frame positions.
    localparam logic [6:0] POS_START     = 7'd0;
    localparam logic [6:0] POS_SYNC_ONE  = 7'd1;
    localparam logic [6:0] POS_SYNC_TWO  = 7'd2;
    localparam logic [6:0] POS_CLASS     = 7'd3;
    localparam logic [6:0] POS_ID        = 7'd4;
    localparam logic [6:0] POS_MONTH     = 7'd21;
    localparam logic [6:0] POS_MINUTE    = 7'd24;
    localparam logic [6:0] POS_FLAGS     = 7'd26;
    localparam logic [6:0] POS_TIME_CKA  = 7'd27;
    localparam logic [6:0] POS_TIME_END  = 7'd28;
    localparam logic [6:0] POS_SET_PRE   = 7'd99;
    localparam logic [6:0] POS_SET_FIRST = 7'd100;
    localparam logic [6:0] POS_SET_LAST  = 7'd105;
    localparam logic [6:0] POS_SET_CKA   = 7'd106;
    localparam logic [6:0] POS_SET_END   = 7'd107;

    // Captured payload slots.
    localparam int CAP_DEPTH = 11;
    localparam logic [3:0] CAP_ON_HIGH  = 4'd0;
    localparam logic [3:0] CAP_ON_LOW   = 4'd1;
    localparam logic [3:0] CAP_OFF_HIGH = 4'd2;
    localparam logic [3:0] CAP_OFF_LOW  = 4'd3;
    localparam logic [3:0] CAP_LIMIT    = 4'd4;
    localparam logic [3:0] CAP_SKIP     = 4'd5;
    localparam logic [3:0] CAP_MONTH    = 4'd6;
    localparam logic [3:0] CAP_DAY      = 4'd7;
    localparam logic [3:0] CAP_HOUR     = 4'd8;
    localparam logic [3:0] CAP_MINUTE   = 4'd9;
    localparam logic [3:0] CAP_FLAGS    = 4'd10;

    localparam int FLAG_UTC_VALID = 2;

endpackage

// File: rtl/gnss_time_frame_dimmer.sv
// Top level: serial frame parser that drives a timed lamp dimmer.
//
// Each input transfer is one received byte or one idle tick, and each yields
// exactly one result transfer carrying the lamp duty, drive, LED and any
// character to send. The block takes one input per clock: an input register
// feeds a single processing stage that updates the parser state and loads the
// result register, so throughput is one transfer per cycle, limited only by
// m_ready. Frames with a bad Fletcher checksum are
// dropped silently; idle_limit may be written through cfg_wr_en at any time
// the block is idle.
module gnss_time_frame_dimmer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gtfd_pkg::gtfd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gtfd_pkg::gtfd_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);
    import gtfd_pkg::*;

    logic       in_valid_reg;
    gtfd_in_t   in_data_reg;
    logic       out_valid_reg;
    gtfd_out_t  out_data_reg;
    gtfd_out_t  out_data_next;
    logic       proc_fire;

    logic [7:0]  idle_limit_reg;
    logic [6:0]  frame_pos_reg,    frame_pos_next;
    logic [7:0]  sum_a_reg,        sum_a_next;
    logic [7:0]  sum_b_reg,        sum_b_next;
    logic [15:0] window_start_reg, window_start_next;
    logic [15:0] window_end_reg,   window_end_next;
    logic [7:0]  duty_limit_reg,   duty_limit_next;
    logic [7:0]  skip_setting_reg, skip_setting_next;
    logic [7:0]  skip_count_reg,   skip_count_next;
    logic [7:0]  duty_level_reg,   duty_level_next;
    logic        drive_state_reg,  drive_state_next;
    logic        led_state_reg,    led_state_next;
    logic [7:0]  idle_count_reg,   idle_count_next;
    logic [7:0]  cap_reg [CAP_DEPTH];
    logic [7:0]  ck_a_reg;

    logic [7:0]  rx;
    logic [6:0]  pos;
    logic        hdr_bad;
    logic [6:0]  pos_eff;
    logic [7:0]  base_a, base_b, acc_a, acc_b;
    logic        in_sum;
    logic        frame_end;
    logic        check_ok;
    logic [15:0] date, local_time;
    logic        in_window;

    // Handshake: the input register drains whenever the result register can load.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    assign rx  = in_data_reg.rx_byte;
    assign pos = frame_pos_reg;

    // A header mismatch restarts the parser; a settings start byte at the
    // first header position opens a settings frame instead.
    assign hdr_bad = (pos == POS_SYNC_ONE && rx != SYNC_ONE) ||
                     (pos == POS_SYNC_TWO && rx != SYNC_TWO) ||
                     (pos == POS_CLASS    && rx != CLASS_NAV) ||
                     (pos == POS_ID       && rx != ID_TIMEUTC);
    assign pos_eff = !hdr_bad ? pos :
                     ((pos == POS_SYNC_ONE && rx == SET_START) ? POS_SET_PRE : POS_START);

    assign base_a = hdr_bad ? 8'd0 : sum_a_reg;
    assign base_b = hdr_bad ? 8'd0 : sum_b_reg;
    assign in_sum = (pos_eff >= POS_CLASS && pos_eff <= POS_FLAGS) ||
                    (pos_eff >= POS_SET_FIRST && pos_eff <= POS_SET_LAST);
    assign acc_a  = in_sum ? 8'(base_a + rx) : base_a;
    assign acc_b  = in_sum ? 8'(base_b + acc_a) : base_b;

    assign frame_end = (pos_eff == POS_TIME_END) || (pos_eff == POS_SET_END);
    // The second check byte is the current byte itself.
    assign check_ok  = (acc_a == ck_a_reg) && (acc_b == rx);

    assign date = 16'({8'd0, cap_reg[CAP_MONTH]} * 16'd100) + {8'd0, cap_reg[CAP_DAY]};
    assign local_time = ((date >= WINTER_FROM || date < WINTER_UNTIL) ?
                         OFFSET_WINTER : OFFSET_SUMMER)
                        + 16'({8'd0, cap_reg[CAP_HOUR]} * 16'd100)
                        + {8'd0, cap_reg[CAP_MINUTE]};
    assign in_window = (local_time >= window_start_reg && local_time < window_end_reg) ||
                       ((local_time >= window_start_reg || local_time < window_end_reg) &&
                        window_start_reg > window_end_reg);

    always_comb begin
        frame_pos_next    = frame_pos_reg;
        sum_a_next        = sum_a_reg;
        sum_b_next        = sum_b_reg;
        window_start_next = window_start_reg;
        window_end_next   = window_end_reg;
        duty_limit_next   = duty_limit_reg;
        skip_setting_next = skip_setting_reg;
        skip_count_next   = skip_count_reg;
        duty_level_next   = duty_level_reg;
        drive_state_next  = drive_state_reg;
        led_state_next    = led_state_reg;
        idle_count_next   = idle_count_reg;
        out_data_next.tx_valid = 1'b0;
        out_data_next.tx_char  = 8'd0;

        if (in_data_reg.kind == KIND_IDLE) begin
            if (idle_count_reg == idle_limit_reg) begin
                out_data_next.tx_valid = 1'b1;
                out_data_next.tx_char  = CHAR_READY;
                led_state_next  = 1'b0;
                idle_count_next = idle_count_reg + 8'd1;
            end else if (idle_count_reg < idle_limit_reg) begin
                idle_count_next = idle_count_reg + 8'd1;
            end
        end else begin
            idle_count_next = 8'd0;
            sum_a_next      = acc_a;
            sum_b_next      = acc_b;
            frame_pos_next  = pos_eff + 7'd1;
            if (frame_end) begin
                if (check_ok) begin
                    if (pos_eff == POS_SET_END) begin
                        window_start_next = {cap_reg[CAP_ON_HIGH], cap_reg[CAP_ON_LOW]};
                        window_end_next   = {cap_reg[CAP_OFF_HIGH], cap_reg[CAP_OFF_LOW]};
                        duty_limit_next   = cap_reg[CAP_LIMIT];
                        skip_setting_next = cap_reg[CAP_SKIP];
                        out_data_next.tx_valid = 1'b1;
                        out_data_next.tx_char  = CHAR_UPDATED;
                    end else if (cap_reg[CAP_FLAGS][FLAG_UTC_VALID]) begin
                        led_state_next = 1'b1;
                        if (skip_count_reg < skip_setting_reg) begin
                            skip_count_next = skip_count_reg + 8'd1;
                        end else begin
                            skip_count_next = 8'd0;
                            if (in_window) begin
                                if (duty_level_reg < duty_limit_reg) begin
                                    duty_level_next = duty_level_reg + 8'd1;
                                end else if (duty_level_reg > duty_limit_reg) begin
                                    duty_level_next = duty_level_reg - 8'd1;
                                end
                                drive_state_next = 1'b1;
                            end else if (duty_level_reg != 8'd0) begin
                                duty_level_next = duty_level_reg - 8'd1;
                            end else begin
                                drive_state_next = 1'b0;
                            end
                        end
                    end
                end
                sum_a_next     = 8'd0;
                sum_b_next     = 8'd0;
                frame_pos_next = POS_SYNC_ONE;
            end
        end

        out_data_next.duty_out  = duty_level_next;
        out_data_next.drive_out = drive_state_next;
        out_data_next.led_out   = led_state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            idle_limit_reg   <= IDLE_RESET;
            frame_pos_reg    <= POS_START;
            sum_a_reg        <= 8'd0;
            sum_b_reg        <= 8'd0;
            window_start_reg <= 16'd0;
            window_end_reg   <= 16'd0;
            duty_limit_reg   <= 8'd0;
            skip_setting_reg <= 8'd0;
            skip_count_reg   <= 8'd0;
            duty_level_reg   <= 8'd0;
            drive_state_reg  <= 1'b0;
            led_state_reg    <= 1'b0;
            idle_count_reg   <= 8'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                idle_limit_reg <= cfg_wr_data;
            end
            if (proc_fire) begin
                frame_pos_reg    <= frame_pos_next;
                sum_a_reg        <= sum_a_next;
                sum_b_reg        <= sum_b_next;
                window_start_reg <= window_start_next;
                window_end_reg   <= window_end_next;
                duty_limit_reg   <= duty_limit_next;
                skip_setting_reg <= skip_setting_next;
                skip_count_reg   <= skip_count_next;
                duty_level_reg   <= duty_level_next;
                drive_state_reg  <= drive_state_next;
                led_state_reg    <= led_state_next;
                idle_count_reg   <= idle_count_next;
            end
        end
    end

    // Payload registers and the capture store carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proc_fire) begin
            out_data_reg <= out_data_next;
        end
        if (proc_fire && in_data_reg.kind == KIND_BYTE) begin
            if (pos_eff >= POS_SET_FIRST && pos_eff <= POS_SET_LAST) begin
                cap_reg[4'(pos_eff - POS_SET_FIRST)] <= rx;
            end else if (pos_eff >= POS_MONTH && pos_eff <= POS_MINUTE) begin
                cap_reg[4'(pos_eff - POS_MONTH) + CAP_MONTH] <= rx;
            end else if (pos_eff == POS_FLAGS) begin
                cap_reg[CAP_FLAGS] <= rx;
            end else if (pos_eff == POS_TIME_CKA || pos_eff == POS_SET_CKA) begin
                ck_a_reg <= rx;
            end
        end
    end

endmodule

// File: rtl/gtfd_checker.sv
// Port-level checker for the time frame dimmer, bound to the top level.
module gtfd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input gtfd_pkg::gtfd_out_t m_data
);
    import gtfd_pkg::*;

    logic       have_last_reg;
    logic [7:0] last_duty_reg;

    // Remember the duty of the previous result transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_last_reg <= 1'b0;
            last_duty_reg <= 8'd0;
        end else if (m_valid && m_ready) begin
            have_last_reg <= 1'b1;
            last_duty_reg <= m_data.duty_out;
        end
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_char_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.tx_valid && (m_data.tx_char == CHAR_READY ||
                                         m_data.tx_char == CHAR_UPDATED)) ||
                    (!m_data.tx_valid && m_data.tx_char == 8'd0))
        else $error("bad transmit character");

    a_ready_led_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tx_valid && m_data.tx_char == CHAR_READY |-> !m_data.led_out)
        else $error("LED lit on a ready character");

    a_duty_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && have_last_reg |->
            (m_data.duty_out == last_duty_reg ||
             m_data.duty_out == 8'(last_duty_reg + 8'd1) ||
             m_data.duty_out == 8'(last_duty_reg - 8'd1)))
        else $error("duty moved by more than one step");

endmodule

bind gnss_time_frame_dimmer gtfd_checker u_gtfd_checker (.*);
